// ----- hw/rtl/bmtb_pkg.sv -----
// bmtb_pkg: item types, register codes and size constants of the corner turn buffer
// no dependencies; imported by block_matrix_transpose_buffer_top
package bmtb_pkg;

    localparam int DATA_W           = 64;
    localparam int SIZE_W           = 13;
    localparam int TOTAL_W          = 3 * SIZE_W;
    localparam int DEFAULT_CAPACITY = 4096;
    localparam int CFG_IDX_W        = 2;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS       = 2'd0,
        CFG_COLUMNS    = 2'd1,
        CFG_GROUP_SIZE = 2'd2
    } t_cfg_idx;

    // input item opcodes
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] in_re;
        logic [DATA_W-1:0] in_im;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] out_re;
        logic [DATA_W-1:0] out_im;
        logic              last;
        logic              config_error;
    } t_out_item;

endpackage

// ----- hw/rtl/block_matrix_transpose_buffer_top.sv -----
// block_matrix_transpose_buffer_top: double-buffered corner turn with a two-bank memory
// depends on bmtb_pkg (item types, register codes, constants)
//
// usage
//   input channel (i_in_valid / o_in_ready / i_in_item): a data item writes one complex
//   element into the fill bank in source order, a flush item writes nothing; every item
//   also reads one element of the full bank in transposed order, once a frame is there
//   output channel (o_out_valid / i_out_ready / o_out_item): zero or one result per item,
//   last marks the final element of a transposed frame, config_error flags bad sizes
//   configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data): rows,
//   columns, group_size; a write drops both frames in progress and keeps the bank select
//   a result is registered and is on the output in the cycle after its item is accepted
//   throughput: one item per cycle while the input is not held off, set by the single
//   write port and single read port of the bank memory (one element in, one element out per item)
//   after a register write the input channel holds off while the frame
//   size products and the size check go through their registers
//   a stalled receiver stalls the input only when the output register is full; items
//   are still taken in the cycle the pending result is taken
//   reset clears counters, bank select, frame flag and output valid; the memory is not
//   cleared and needs no clearing pass, it is only read where it was written
module block_matrix_transpose_buffer_top
    import bmtb_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    // index width of one bank, and a compare width that holds indexes and sizes plus one
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW    = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
    localparam int MW    = AW + 1;
    localparam int DEPTH = 2 << AW;
    localparam int RC_W  = 2 * SIZE_W;

    // configuration and derived sizes
    logic [SIZE_W-1:0]  r_rows, r_columns, r_group_size;
    logic [RC_W-1:0]    r_rc, r_gc;
    logic [TOTAL_W-1:0] r_total;
    logic               r_bad;
    logic [1:0]         r_hold;

    // fill side and readout side state
    logic [AW-1:0] r_widx, n_widx;
    logic          r_wbank, n_wbank;
    logic          r_frame, n_frame;
    logic [AW-1:0] r_spos, n_spos;
    logic [AW-1:0] r_ipos, n_ipos;
    logic [AW-1:0] r_jpos, n_jpos;
    logic [AW-1:0] r_base, n_base;
    logic [AW-1:0] r_cbase, n_cbase;

    // bank memory and output register
    logic [2*DATA_W-1:0] r_mem [DEPTH];
    logic [2*DATA_W-1:0] r_rdata;
    logic [2*DATA_W-1:0] r_fwd_data;
    logic                r_fwd;
    logic                r_ov;
    logic                r_last;
    logic                r_err;

    logic          in_acc;
    logic          cfg_acc;
    logic          cfg_hit;
    logic          mem_we, mem_re, emit, fwd, is_last;
    logic          wr, wdone;
    logic [MW-1:0] waddr, raddr;
    logic [AW-1:0] m_spos, m_ipos, m_jpos, m_base, m_cbase;
    logic [AW-1:0] gs_a;
    logic [AW-1:0] gc_a;
    logic          s_wrap, i_wrap;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign o_in_ready  = (r_hold == 2'd0) && (!r_ov || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        unique case (t_cfg_idx'(i_cfg_index))
            CFG_ROWS, CFG_COLUMNS, CFG_GROUP_SIZE: cfg_hit = cfg_acc;
            default:                               cfg_hit = 1'b0;
        endcase
    end

    assign gs_a = AW'(r_group_size);
    assign gc_a = AW'(r_gc);

    // one item: write first, swap banks on a full frame, then read one element
    always_comb begin
        wr     = in_acc && !r_bad && (i_in_item.command == CMD_DATA);
        wdone  = wr && ((TOTAL_W'(r_widx) + TOTAL_W'(1)) >= r_total);
        waddr  = {r_wbank, r_widx};
        mem_we = wr;

        n_widx  = r_widx;
        n_wbank = r_wbank;
        n_frame = r_frame;
        if (wr) begin
            n_widx = wdone ? '0 : r_widx + AW'(1);
        end
        if (wdone) begin
            n_wbank = ~r_wbank;
            n_frame = 1'b1;
        end

        // positions after a possible restart of the readout
        m_spos  = wdone ? '0 : r_spos;
        m_ipos  = wdone ? '0 : r_ipos;
        m_jpos  = wdone ? '0 : r_jpos;
        m_base  = wdone ? '0 : r_base;
        m_cbase = wdone ? '0 : r_cbase;

        emit    = in_acc && !r_bad && n_frame;
        mem_re  = emit;
        raddr   = {~n_wbank, m_base + m_spos};
        fwd     = wr && (raddr == waddr);
        s_wrap  = (LW'(m_spos) + LW'(1)) == LW'(r_group_size);
        i_wrap  = (LW'(m_ipos) + LW'(1)) == LW'(r_rows);
        is_last = s_wrap && i_wrap && ((LW'(m_jpos) + LW'(1)) == LW'(r_columns));

        n_spos  = m_spos;
        n_ipos  = m_ipos;
        n_jpos  = m_jpos;
        n_base  = m_base;
        n_cbase = m_cbase;
        if (emit) begin
            if (is_last) begin
                n_frame = 1'b0;
                n_spos  = '0;
                n_ipos  = '0;
                n_jpos  = '0;
                n_base  = '0;
                n_cbase = '0;
            end else if (!s_wrap) begin
                n_spos = m_spos + AW'(1);
            end else begin
                n_spos = '0;
                if (i_wrap) begin
                    // next structure column: base = j * group_size
                    n_ipos  = '0;
                    n_jpos  = m_jpos + AW'(1);
                    n_cbase = m_cbase + gs_a;
                    n_base  = m_cbase + gs_a;
                end else begin
                    n_ipos = m_ipos + AW'(1);
                    n_base = m_base + gc_a;
                end
            end
        end
    end

    // sizes, their products and the size check, each product registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= SIZE_W'(1);
            r_columns    <= SIZE_W'(1);
            r_group_size <= SIZE_W'(1);
            r_rc         <= RC_W'(1);
            r_gc         <= RC_W'(1);
            r_total      <= TOTAL_W'(1);
            r_bad        <= 1'b0;
            r_hold       <= 2'd0;
        end else begin
            if (cfg_acc) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_ROWS:       r_rows       <= i_cfg_data;
                    CFG_COLUMNS:    r_columns    <= i_cfg_data;
                    CFG_GROUP_SIZE: r_group_size <= i_cfg_data;
                    default:        ;
                endcase
            end
            r_rc    <= RC_W'(r_rows) * RC_W'(r_columns);
            r_gc    <= RC_W'(r_group_size) * RC_W'(r_columns);
            r_total <= TOTAL_W'(r_rc) * TOTAL_W'(r_group_size);
            r_bad   <= (r_rows == '0) || (r_columns == '0) || (r_group_size == '0)
                       || (r_total > TOTAL_W'(CAPACITY));
            if (cfg_hit) begin
                r_hold <= 2'd3;
            end else if (r_hold != 2'd0) begin
                r_hold <= r_hold - 2'd1;
            end
        end
    end

    // frame state and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx  <= '0;
            r_wbank <= 1'b0;
            r_frame <= 1'b0;
            r_spos  <= '0;
            r_ipos  <= '0;
            r_jpos  <= '0;
            r_base  <= '0;
            r_cbase <= '0;
            r_ov    <= 1'b0;
            r_last  <= 1'b0;
            r_err   <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (cfg_hit) begin
                r_widx  <= '0;
                r_frame <= 1'b0;
                r_spos  <= '0;
                r_ipos  <= '0;
                r_jpos  <= '0;
                r_base  <= '0;
                r_cbase <= '0;
            end else begin
                r_widx  <= n_widx;
                r_wbank <= n_wbank;
                r_frame <= n_frame;
                r_spos  <= n_spos;
                r_ipos  <= n_ipos;
                r_jpos  <= n_jpos;
                r_base  <= n_base;
                r_cbase <= n_cbase;
            end
            if (in_acc && (r_bad || emit)) begin
                r_ov   <= 1'b1;
                r_err  <= r_bad;
                r_last <= emit && is_last;
                r_fwd  <= fwd;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // bank memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= {i_in_item.in_re, i_in_item.in_im};
        end
        if (mem_re) begin
            r_rdata <= r_mem[raddr];
        end
        // single-element frame reads the element written by the same item
        if (emit && fwd) begin
            r_fwd_data <= {i_in_item.in_re, i_in_item.in_im};
        end
    end

    always_comb begin
        o_out_valid = r_ov;
        if (r_err) begin
            o_out_item.out_re = '0;
            o_out_item.out_im = '0;
        end else if (r_fwd) begin
            o_out_item.out_re = r_fwd_data[2*DATA_W-1:DATA_W];
            o_out_item.out_im = r_fwd_data[DATA_W-1:0];
        end else begin
            o_out_item.out_re = r_rdata[2*DATA_W-1:DATA_W];
            o_out_item.out_im = r_rdata[DATA_W-1:0];
        end
        o_out_item.last         = r_last;
        o_out_item.config_error = r_err;
    end

`ifndef ASSERT_OFF
    // size products must settle before an item is taken
    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold != 2'd0) |-> !o_in_ready)
        else $error("item taken while size check settles");

    // fill index stays inside the frame
    a_widx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_hold == 2'd0) && !r_bad) |-> (TOTAL_W'(r_widx) < r_total))
        else $error("write index beyond frame size");

    // bad sizes answer every item with an error result
    a_bad_gives_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_bad) |=> (r_ov && r_err && !r_last))
        else $error("missing error result");

    // read and write of one address in one item only for one-element frames
    a_fwd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_fwd && !r_err) |-> (r_total == TOTAL_W'(1)))
        else $error("forwarding on a frame larger than one element");

    // the frame flag is clear after the last element of a frame, unless that item also completed a fill
    a_last_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && emit && is_last) |=> !r_frame || $past(wdone))
        else $error("frame flag left set after last element");
`endif

endmodule
